// File: hdl/nidc_pkg.sv
// ----------------------------------------------------------------------------
// nidc_pkg
// Shared types, constants and helpers for the identity number check decoder.
// ----------------------------------------------------------------------------
package nidc_pkg;

   localparam logic [3:0] IdLen    = 4'd11;
   localparam logic [3:0] PosMax   = 4'd15;
   localparam logic [7:0] CharZero = 8'd48;
   localparam logic [7:0] CharNine = 8'd57;
   localparam logic [6:0] MonthMax = 7'd12;
   localparam logic [6:0] DayMax   = 7'd31;

   // digit positions (zero based) that bound each field
   localparam logic [3:0] PosMonth = 4'd2;
   localparam logic [3:0] PosDay   = 4'd4;
   localparam logic [3:0] PosTail  = 4'd6;
   localparam logic [3:0] PosTenth = 4'd9;
   localparam logic [3:0] PosCheck = 4'd10;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEN   = 3'd1,
      ST_NON_DIGIT = 3'd2,
      ST_BAD_SUM   = 3'd3,
      ST_BAD_DATE  = 3'd4
   } status_type;

   typedef struct packed {
      status_type status;
      logic       is_male;
      logic [6:0] birth_day;
      logic [6:0] birth_month;
      logic [6:0] birth_year;
   } result_type;

   // checksum weights 1,3,7,9 repeating; check digit weight 1
   function automatic logic [3:0] digit_weight(input logic [3:0] pos);
      logic [3:0] w;
      begin
         if (pos == PosCheck) begin
            w = 4'd1;
         end else begin
            case (pos[1:0])
               2'd1:    w = 4'd3;
               2'd2:    w = 4'd7;
               2'd3:    w = 4'd9;
               default: w = 4'd1;
            endcase
         end
         digit_weight = w;
      end
   endfunction

   // val < 100: quotient by reciprocal 205/2048
   function automatic logic [3:0] mod_ten(input logic [6:0] val);
      logic [14:0] prod;
      logic [3:0]  quo;
      logic [7:0]  tens;
      logic [7:0]  rem;
      begin
         prod    = {8'd0, val} * 15'd205;
         quo     = prod[14:11];
         tens    = {4'd0, quo} * 8'd10;
         rem     = {1'b0, val} - tens;
         mod_ten = rem[3:0];
      end
   endfunction

   function automatic logic [6:0] two_digit(input logic [6:0] acc, input logic [3:0] d);
      logic [10:0] t;
      begin
         t         = ({4'd0, acc} * 11'd10) + {7'd0, d};
         two_digit = t[6:0];
      end
   endfunction

endpackage

// File: hdl/nidc_in_stage.sv
// ----------------------------------------------------------------------------
// nidc_in_stage
// Input register: holds one character beat until the accumulator takes it.
// ----------------------------------------------------------------------------
module nidc_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_is_last,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_char,
   output logic       held_last
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= req_char_code;
         last_ff <= req_is_last;
      end
   end

   assign held_valid = valid_ff;
   assign held_char  = char_ff;
   assign held_last  = last_ff;

endmodule

// File: hdl/nidc_accum.sv
// ----------------------------------------------------------------------------
// nidc_accum
// Per-character state update and result formation on the last beat.
// ----------------------------------------------------------------------------
module nidc_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            char_code,
   input  logic                  is_last,
   output nidc_pkg::result_type  result
);

   logic [3:0] pos_ff,   pos_in;
   logic [3:0] sum_ff,   sum_in;
   logic [6:0] year_ff,  year_in;
   logic [6:0] month_ff, month_in;
   logic [6:0] day_ff,   day_in;
   logic       odd_ff,   odd_in;
   logic       nd_ff,    nd_in;

   logic       is_digit;
   logic [7:0] diff;
   logic [3:0] d;
   logic [7:0] prod;
   logic [6:0] sum_raw;
   logic       in_range;
   nidc_pkg::status_type status;

   always_comb begin
      is_digit = (char_code >= nidc_pkg::CharZero) && (char_code <= nidc_pkg::CharNine);
      diff     = char_code - nidc_pkg::CharZero;
      d        = is_digit ? diff[3:0] : 4'd0;
      prod     = {4'd0, d} * {4'd0, nidc_pkg::digit_weight(pos_ff)};
      sum_raw  = {3'd0, sum_ff} + prod[6:0];
      in_range = pos_ff < nidc_pkg::IdLen;

      nd_in    = nd_ff || !is_digit;
      sum_in   = sum_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      odd_in   = odd_ff;
      if (in_range) begin
         sum_in = nidc_pkg::mod_ten(sum_raw);
         if (pos_ff < nidc_pkg::PosMonth) begin
            year_in = nidc_pkg::two_digit(year_ff, d);
         end else if (pos_ff < nidc_pkg::PosDay) begin
            month_in = nidc_pkg::two_digit(month_ff, d);
         end else if (pos_ff < nidc_pkg::PosTail) begin
            day_in = nidc_pkg::two_digit(day_ff, d);
         end else if (pos_ff == nidc_pkg::PosTenth) begin
            odd_in = d[0];
         end
      end
      pos_in = (pos_ff == nidc_pkg::PosMax) ? pos_ff : pos_ff + 4'd1;

      if (pos_in != nidc_pkg::IdLen) begin
         status = nidc_pkg::ST_BAD_LEN;
      end else if (nd_in) begin
         status = nidc_pkg::ST_NON_DIGIT;
      end else if (sum_in != 4'd0) begin
         status = nidc_pkg::ST_BAD_SUM;
      end else if (month_in == 7'd0 || month_in > nidc_pkg::MonthMax ||
                   day_in == 7'd0 || day_in > nidc_pkg::DayMax) begin
         status = nidc_pkg::ST_BAD_DATE;
      end else begin
         status = nidc_pkg::ST_OK;
      end

      result.status      = status;
      result.is_male     = (status == nidc_pkg::ST_OK) ? odd_in : 1'b0;
      result.birth_day   = day_in;
      result.birth_month = month_in;
      result.birth_year  = year_in;
   end

   // last beat clears everything for the next number
   always_ff @(posedge clock) begin
      if (reset || (step && is_last)) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         year_ff  <= '0;
         month_ff <= '0;
         day_ff   <= '0;
         odd_ff   <= 1'b0;
         nd_ff    <= 1'b0;
      end else if (step) begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         odd_ff   <= odd_in;
         nd_ff    <= nd_in;
      end
   end

endmodule

// File: hdl/nidc_out_stage.sv
// ----------------------------------------------------------------------------
// nidc_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module nidc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  nidc_pkg::result_type result,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nidc_pkg::result_type rsp_data
);

   logic                 valid_ff, valid_in;
   nidc_pkg::result_type data_ff;

   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hdl/national_id_check_decode.sv
// A last beat passes the input register, then its result the result register.
// Throughput: one character per cycle while not stalled; one input register,
// one state update, one result register.
// A held result only stalls a last character; other beats keep flowing.
// Reset (synchronous) clears the position, sum, date fields and both valid flags.
// ----------------------------------------------------------------------------
// national_id_check_decode
// Streams identity number characters, checks length, digits, checksum and date.
// ----------------------------------------------------------------------------
module national_id_check_decode (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic       rsp_is_male,
   output logic [6:0] rsp_birth_day,
   output logic [6:0] rsp_birth_month,
   output logic [6:0] rsp_birth_year
);

   logic                 held_valid;
   logic [7:0]           held_char;
   logic                 held_last;
   logic                 advance;
   logic                 room;
   nidc_pkg::result_type result;
   nidc_pkg::result_type rsp_data;

   // a non-last beat never needs the result slot
   assign advance = held_valid && (!held_last || room);

   nidc_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .advance       (advance),
      .held_valid    (held_valid),
      .held_char     (held_char),
      .held_last     (held_last)
   );

   nidc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (held_char),
      .is_last   (held_last),
      .result    (result)
   );

   nidc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && held_last),
      .result    (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status      = rsp_data.status;
   assign rsp_is_male     = rsp_data.is_male;
   assign rsp_birth_day   = rsp_data.birth_day;
   assign rsp_birth_month = rsp_data.birth_month;
   assign rsp_birth_year  = rsp_data.birth_year;

endmodule
